### rtl/tmbb_pkg.sv
// Shared types, constants and saturation helpers for the mesh bounding box block.
package tmbb_pkg;

  localparam int unsigned COORD_W         = 32;
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned PROD_W          = 2 * COORD_W - COORD_FRAC_BITS;
  localparam int unsigned SUM_W           = PROD_W + 2;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QUEUE_AW        = 2;
  localparam int unsigned CFG_IDX_W       = 3;

  typedef logic signed [COORD_W-1:0]   coord_t;
  typedef logic signed [2*COORD_W-1:0] wide_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic signed [COORD_W:0]     coord_ext_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t COORD_ONE = coord_t'(64'sd1 << COORD_FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_M_XX       = 3'd0,
    CFG_M_XY       = 3'd1,
    CFG_M_YX       = 3'd2,
    CFG_M_YY       = 3'd3,
    CFG_SHIFT_X    = 3'd4,
    CFG_SHIFT_Y    = 3'd5,
    CFG_FAT_RADIUS = 3'd6
  } tmbb_cfg_idx_e;

  typedef struct packed {
    coord_t m_xx;
    coord_t m_xy;
    coord_t m_yx;
    coord_t m_yy;
    coord_t shift_x;
    coord_t shift_y;
    coord_t fat_radius;
  } tmbb_cfg_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } tmbb_box_t;

  typedef struct packed {
    tmbb_box_t box;
    logic      mesh_end;
  } tmbb_poly_t;

  localparam tmbb_box_t BOX_EMPTY = '{
    min_x: COORD_MAX, min_y: COORD_MAX, max_x: COORD_MIN, max_y: COORD_MIN
  };

  // Clamp a one-bit-grown sum to the coordinate range.
  function automatic coord_t sat_ext(coord_ext_t s);
    coord_t r;
    if (s[COORD_W] != s[COORD_W-1]) begin
      r = s[COORD_W] ? COORD_MIN : COORD_MAX;
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

  // Clamp a transform sum to the coordinate range.
  function automatic coord_t sat_sum(sum_t s);
    logic [SUM_W-COORD_W:0] hi;
    coord_t                 r;
    hi = s[SUM_W-1:COORD_W-1];
    if ((&hi) || (~|hi)) begin
      r = s[COORD_W-1:0];
    end else begin
      r = s[SUM_W-1] ? COORD_MIN : COORD_MAX;
    end
    return r;
  endfunction

endpackage

### rtl/tmbb_vtx_if.sv
// Vertex channel: valid/ready handshake carrying one mesh vertex per beat.
interface tmbb_vtx_if;
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    vx;
  logic signed [31:0]    vy;
  logic                  poly_end;
  logic                  mesh_end;

  modport source (output valid, output vx, output vy, output poly_end, output mesh_end,
                  input ready);
  modport sink   (input valid, input vx, input vy, input poly_end, input mesh_end,
                  output ready);
endinterface

### rtl/tmbb_box_if.sv
// Result channel: valid/ready handshake carrying one mesh bounding box per beat.
interface tmbb_box_if;
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    box_min_x;
  logic signed [31:0]    box_min_y;
  logic signed [31:0]    box_max_x;
  logic signed [31:0]    box_max_y;
  logic                  box_empty;

  modport source (output valid, output box_min_x, output box_min_y, output box_max_x,
                  output box_max_y, output box_empty, input ready);
  modport sink   (input valid, input box_min_x, input box_min_y, input box_max_x,
                  input box_max_y, input box_empty, output ready);
endinterface

### rtl/transformed_mesh_bounding_box_top.sv
// Top level of the transformed mesh bounding box block.
// Accepts one vertex per clock while the polygon queue has room. Each vertex that closes a
// polygon (poly_end or mesh_end) places the polygon box into a 4-entry queue; unless a result
// beat is held, the back part drains one polygon per clock through a three-stage pipeline
// (eight 32x32 multipliers, corner sums with saturation, mesh box merge), so the sustained
// rate is one vertex per clock even when every vertex is its own polygon. The vertex input
// stalls only when the queue fills, which happens only while the result beat is held by the
// consumer. A result beat is held in an output register while later vertices keep flowing.
// The configuration port takes one write per clock; no clearing pass follows reset.
module transformed_mesh_bounding_box_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tmbb_vtx_if.sink                    vtx_i,
  tmbb_box_if.source                  box_o,
  input  logic                        cfg_we_i,
  input  logic [tmbb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tmbb_pkg::COORD_W-1:0]   cfg_wdata_i
);
  import tmbb_pkg::*;

  tmbb_cfg_t  cfg_q, cfg_d;
  logic       push;
  tmbb_poly_t push_data;
  logic       full;
  logic       pop;
  logic       head_valid;
  tmbb_poly_t head;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_M_XX:       cfg_d.m_xx       = cfg_wdata_i;
        CFG_M_XY:       cfg_d.m_xy       = cfg_wdata_i;
        CFG_M_YX:       cfg_d.m_yx       = cfg_wdata_i;
        CFG_M_YY:       cfg_d.m_yy       = cfg_wdata_i;
        CFG_SHIFT_X:    cfg_d.shift_x    = cfg_wdata_i;
        CFG_SHIFT_Y:    cfg_d.shift_y    = cfg_wdata_i;
        CFG_FAT_RADIUS: cfg_d.fat_radius = cfg_wdata_i;
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{m_xx: COORD_ONE, m_xy: '0, m_yx: '0, m_yy: COORD_ONE,
                 shift_x: '0, shift_y: '0, fat_radius: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tmbb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vtx_i        (vtx_i),
    .fat_radius_i (cfg_q.fat_radius),
    .full_i       (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  tmbb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .pop_data_o  (head)
  );

  tmbb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .box_o        (box_o)
  );

endmodule

### rtl/tmbb_front.sv
// Front part: grows the polygon box per vertex and hands closed polygons to the queue.
module tmbb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  tmbb_vtx_if.sink            vtx_i,
  input  tmbb_pkg::coord_t    fat_radius_i,
  input  logic                full_i,
  output logic                push_o,
  output tmbb_pkg::tmbb_poly_t push_data_o
);
  import tmbb_pkg::*;

  tmbb_box_t poly_q, poly_d;
  tmbb_box_t grown;
  logic      accept;
  logic      close;

  assign vtx_i.ready = !full_i;
  assign accept      = vtx_i.valid && vtx_i.ready;
  assign close       = vtx_i.poly_end || vtx_i.mesh_end;

  always_comb begin
    coord_t lo_x, lo_y, hi_x, hi_y;
    lo_x  = sat_ext(coord_ext_t'(vtx_i.vx) - coord_ext_t'(fat_radius_i));
    lo_y  = sat_ext(coord_ext_t'(vtx_i.vy) - coord_ext_t'(fat_radius_i));
    hi_x  = sat_ext(coord_ext_t'(vtx_i.vx) + coord_ext_t'(fat_radius_i));
    hi_y  = sat_ext(coord_ext_t'(vtx_i.vy) + coord_ext_t'(fat_radius_i));
    grown = poly_q;
    // Negative radius: drop the vertex.
    if (!fat_radius_i[COORD_W-1]) begin
      if (lo_x < poly_q.min_x) grown.min_x = lo_x;
      if (lo_y < poly_q.min_y) grown.min_y = lo_y;
      if (hi_x > poly_q.max_x) grown.max_x = hi_x;
      if (hi_y > poly_q.max_y) grown.max_y = hi_y;
    end
  end

  assign push_o               = accept && close;
  assign push_data_o.box      = grown;
  assign push_data_o.mesh_end = vtx_i.mesh_end;

  always_comb begin
    poly_d = poly_q;
    if (accept) begin
      poly_d = close ? BOX_EMPTY : grown;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= BOX_EMPTY;
    end else begin
      poly_q <= poly_d;
    end
  end

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && close |=> poly_q == BOX_EMPTY)
    else $error("polygon box not cleared after closing beat");

endmodule

### rtl/tmbb_queue.sv
// Short polygon queue between the front and back parts.
module tmbb_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tmbb_pkg::tmbb_poly_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output tmbb_pkg::tmbb_poly_t pop_data_o
);
  import tmbb_pkg::*;

  tmbb_poly_t            mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]     cnt_q, cnt_d;

  assign full_o     = cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QUEUE_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QUEUE_AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (QUEUE_AW+1)'(push_i) - (QUEUE_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("push into full polygon queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty polygon queue");

endmodule

### rtl/tmbb_back.sv
// Back part: transforms polygon corners and merges them into the mesh box.
module tmbb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tmbb_pkg::tmbb_cfg_t  cfg_i,
  input  logic                 head_valid_i,
  input  tmbb_pkg::tmbb_poly_t head_i,
  output logic                 pop_o,
  tmbb_box_if.source           box_o
);
  import tmbb_pkg::*;

  logic      adv;

  // Stage 1: eight truncated products.
  logic      s1_valid_q, s1_nonempty_q, s1_mend_q;
  prod_t     px_q [2];
  prod_t     py_q [2];
  prod_t     qx_q [2];
  prod_t     qy_q [2];
  prod_t     px_d [2];
  prod_t     py_d [2];
  prod_t     qx_d [2];
  prod_t     qy_d [2];
  logic      head_nonempty;

  // Stage 2: four transformed corners.
  logic      s2_valid_q, s2_nonempty_q, s2_mend_q;
  coord_t    tx_q [4];
  coord_t    ty_q [4];
  coord_t    tx_d [4];
  coord_t    ty_d [4];

  // Stage 3: mesh box and output register.
  tmbb_box_t mesh_q, mesh_d;
  logic      mesh_any_q, mesh_any_d;
  tmbb_box_t merged;
  logic      merge;
  logic      out_valid_q, out_valid_d;
  tmbb_box_t out_box_q, out_box_d;
  logic      out_empty_q, out_empty_d;

  assign adv   = !out_valid_q || box_o.ready;
  assign pop_o = adv && head_valid_i;

  assign head_nonempty = !(head_i.box.max_x < head_i.box.min_x ||
                           head_i.box.max_y < head_i.box.min_y);

  always_comb begin
    coord_t xs [2];
    coord_t ys [2];
    wide_t  p;
    xs[0] = head_i.box.min_x;
    xs[1] = head_i.box.max_x;
    ys[0] = head_i.box.min_y;
    ys[1] = head_i.box.max_y;
    for (int i = 0; i < 2; i++) begin
      p       = $signed(cfg_i.m_xx) * $signed(xs[i]);
      px_d[i] = p[2*COORD_W-1:COORD_FRAC_BITS];
      p       = $signed(cfg_i.m_xy) * $signed(ys[i]);
      py_d[i] = p[2*COORD_W-1:COORD_FRAC_BITS];
      p       = $signed(cfg_i.m_yx) * $signed(xs[i]);
      qx_d[i] = p[2*COORD_W-1:COORD_FRAC_BITS];
      p       = $signed(cfg_i.m_yy) * $signed(ys[i]);
      qy_d[i] = p[2*COORD_W-1:COORD_FRAC_BITS];
    end
  end

  // Corner k uses x bound k/2 and y bound k%2.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      tx_d[k] = sat_sum(sum_t'(px_q[k/2]) + sum_t'(py_q[k%2]) + sum_t'(cfg_i.shift_x));
      ty_d[k] = sat_sum(sum_t'(qx_q[k/2]) + sum_t'(qy_q[k%2]) + sum_t'(cfg_i.shift_y));
    end
  end

  always_comb begin
    merged = mesh_q;
    for (int k = 0; k < 4; k++) begin
      if (tx_q[k] < merged.min_x) merged.min_x = tx_q[k];
      if (ty_q[k] < merged.min_y) merged.min_y = ty_q[k];
      if (tx_q[k] > merged.max_x) merged.max_x = tx_q[k];
      if (ty_q[k] > merged.max_y) merged.max_y = ty_q[k];
    end
  end

  assign merge = s2_valid_q && s2_nonempty_q;

  always_comb begin
    tmbb_box_t next_box;
    logic      next_any;
    next_box    = merge ? merged : mesh_q;
    next_any    = mesh_any_q || merge;
    mesh_d      = mesh_q;
    mesh_any_d  = mesh_any_q;
    out_valid_d = out_valid_q;
    out_box_d   = out_box_q;
    out_empty_d = out_empty_q;
    if (adv) begin
      out_valid_d = s2_valid_q && s2_mend_q;
      if (s2_valid_q && s2_mend_q) begin
        out_box_d   = next_any ? next_box : '0;
        out_empty_d = !next_any;
        mesh_d      = BOX_EMPTY;
        mesh_any_d  = 1'b0;
      end else if (s2_valid_q) begin
        mesh_d     = next_box;
        mesh_any_d = next_any;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_nonempty_q <= head_nonempty;
      s1_mend_q     <= head_i.mesh_end;
      px_q          <= px_d;
      py_q          <= py_d;
      qx_q          <= qx_d;
      qy_q          <= qy_d;
      s2_nonempty_q <= s1_nonempty_q;
      s2_mend_q     <= s1_mend_q;
      tx_q          <= tx_d;
      ty_q          <= ty_d;
    end
    out_box_q   <= out_box_d;
    out_empty_q <= out_empty_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mesh_q      <= BOX_EMPTY;
      mesh_any_q  <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_q <= head_valid_i;
        s2_valid_q <= s1_valid_q;
      end
      out_valid_q <= out_valid_d;
      mesh_q      <= mesh_d;
      mesh_any_q  <= mesh_any_d;
    end
  end

  assign box_o.valid     = out_valid_q;
  assign box_o.box_min_x = out_box_q.min_x;
  assign box_o.box_min_y = out_box_q.min_y;
  assign box_o.box_max_x = out_box_q.max_x;
  assign box_o.box_max_y = out_box_q.max_y;
  assign box_o.box_empty = out_empty_q;

  a_mesh_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s2_valid_q && s2_mend_q |=> out_valid_q)
    else $error("mesh end did not produce a result");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_empty_q |-> out_box_q == '0)
    else $error("empty mesh result carries nonzero bounds");

  a_mesh_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s2_valid_q && s2_mend_q |=> !mesh_any_q && mesh_q == BOX_EMPTY)
    else $error("mesh box not cleared after result");

endmodule

### bench/tb.sv
// Testbench for the transformed mesh bounding box block: random and directed vertex streams.
`timescale 1ns / 100ps

module tb;
  import tmbb_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 12;
  localparam int unsigned PHASE_VERTICES = 140;
  localparam longint      LIM_HI         = 64'sd2147483647;
  localparam longint      LIM_LO         = -64'sd2147483648;
  // Index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  typedef struct packed {
    coord_t vx;
    coord_t vy;
    logic   pend;
    logic   mend;
  } vertex_t;

  typedef struct packed {
    tmbb_box_t box;
    logic      is_empty;
  } box_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COORD_W-1:0]   cfg_wdata;

  tmbb_vtx_if vtx_ch ();
  tmbb_box_if box_ch ();

  transformed_mesh_bounding_box_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .vtx_i       (vtx_ch.sink),
    .box_o       (box_ch.source),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tmbb_cfg_t   xf_cfg;
  tmbb_box_t   poly_acc;
  tmbb_box_t   mesh_acc;
  box_result_t boxes_due[$];
  vertex_t     vtx_pending[$];

  int unsigned n_vertices;
  int unsigned n_meshes;
  int unsigned n_empty;
  int unsigned n_settings;
  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned vtx_gap;
  int unsigned ready_stall;
  bit          vtx_fired;
  bit          steady;

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    vtx_ch.valid    = 1'b0;
    vtx_ch.vx       = '0;
    vtx_ch.vy       = '0;
    vtx_ch.poly_end = 1'b0;
    vtx_ch.mesh_end = 1'b0;
    box_ch.ready    = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > LIM_HI) return LIM_HI;
    if (v < LIM_LO) return LIM_LO;
    return v;
  endfunction

  // Full product, floor-shifted back to the coordinate scale.
  function automatic longint fx_mul(coord_t a, longint b);
    return (longint'($signed(a)) * b) >>> COORD_FRAC_BITS;
  endfunction

  function automatic tmbb_box_t stretch(tmbb_box_t b, longint x0, longint y0,
                                        longint x1, longint y1);
    if (x0 < longint'($signed(b.min_x))) b.min_x = coord_t'(x0);
    if (y0 < longint'($signed(b.min_y))) b.min_y = coord_t'(y0);
    if (x1 > longint'($signed(b.max_x))) b.max_x = coord_t'(x1);
    if (y1 > longint'($signed(b.max_y))) b.max_y = coord_t'(y1);
    return b;
  endfunction

  function automatic bit hollow(tmbb_box_t b);
    return ($signed(b.max_x) < $signed(b.min_x)) || ($signed(b.max_y) < $signed(b.min_y));
  endfunction

  function automatic tmbb_box_t place_corner(tmbb_box_t m, longint x, longint y);
    longint tx;
    longint ty;
    tx = clamp32(fx_mul(xf_cfg.m_xx, x) + fx_mul(xf_cfg.m_xy, y)
                 + longint'($signed(xf_cfg.shift_x)));
    ty = clamp32(fx_mul(xf_cfg.m_yx, x) + fx_mul(xf_cfg.m_yy, y)
                 + longint'($signed(xf_cfg.shift_y)));
    return stretch(m, tx, ty, tx, ty);
  endfunction

  task automatic track_vertex(vertex_t v);
    longint      r;
    longint      px;
    longint      py;
    longint      lx;
    longint      ly;
    longint      hx;
    longint      hy;
    box_result_t res;
    r  = longint'($signed(xf_cfg.fat_radius));
    px = longint'($signed(v.vx));
    py = longint'($signed(v.vy));
    // A negative radius leaves the polygon box untouched.
    if (r >= 0) begin
      poly_acc = stretch(poly_acc, clamp32(px - r), clamp32(py - r),
                         clamp32(px + r), clamp32(py + r));
    end
    if (v.pend || v.mend) begin
      if (!hollow(poly_acc)) begin
        lx = longint'($signed(poly_acc.min_x));
        ly = longint'($signed(poly_acc.min_y));
        hx = longint'($signed(poly_acc.max_x));
        hy = longint'($signed(poly_acc.max_y));
        mesh_acc = place_corner(mesh_acc, lx, ly);
        mesh_acc = place_corner(mesh_acc, lx, hy);
        mesh_acc = place_corner(mesh_acc, hx, hy);
        mesh_acc = place_corner(mesh_acc, hx, ly);
      end
      poly_acc = BOX_EMPTY;
    end
    if (v.mend) begin
      res.is_empty = hollow(mesh_acc);
      res.box      = res.is_empty ? tmbb_box_t'('0) : mesh_acc;
      boxes_due.push_back(res);
      n_meshes++;
      if (res.is_empty) n_empty++;
      mesh_acc = BOX_EMPTY;
    end
  endtask

  task automatic check_word(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endtask

  function automatic int unsigned pick_pause();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Result side: sample beats, predict on vertex beats, watch for a hang.
  always @(posedge clk) begin : beat_monitor
    vertex_t     seen;
    box_result_t want;
    bit          box_fired;
    if (rst_n) begin
      vtx_fired = vtx_ch.valid && vtx_ch.ready;
      box_fired = box_ch.valid && box_ch.ready;
      if (vtx_fired) begin
        seen.vx   = vtx_ch.vx;
        seen.vy   = vtx_ch.vy;
        seen.pend = vtx_ch.poly_end;
        seen.mend = vtx_ch.mesh_end;
        track_vertex(seen);
        n_vertices++;
      end
      if (box_fired) begin
        if (boxes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected box beat: expected none, got %h %h %h %h empty %b",
                   $time, box_ch.box_min_x, box_ch.box_min_y, box_ch.box_max_x,
                   box_ch.box_max_y, box_ch.box_empty);
        end else begin
          want = boxes_due.pop_front();
          check_word("box_min_x", want.box.min_x, box_ch.box_min_x);
          check_word("box_min_y", want.box.min_y, box_ch.box_min_y);
          check_word("box_max_x", want.box.max_x, box_ch.box_max_x);
          check_word("box_max_y", want.box.max_y, box_ch.box_max_y);
          check_word("box_empty", {31'b0, want.is_empty}, {31'b0, box_ch.box_empty});
        end
      end
      if (vtx_fired || box_fired) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles, %0d boxes outstanding",
                   $time, idle_cycles, boxes_due.size());
          $display("tb: FAIL");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin : vtx_driver
    vertex_t nxt;
    if (rst_n && (!vtx_ch.valid || vtx_fired)) begin
      if (vtx_gap > 0 || vtx_pending.size() == 0) begin
        vtx_ch.valid <= 1'b0;
        if (vtx_gap > 0) vtx_gap--;
      end else begin
        nxt = vtx_pending.pop_front();
        vtx_ch.valid    <= 1'b1;
        vtx_ch.vx       <= nxt.vx;
        vtx_ch.vy       <= nxt.vy;
        vtx_ch.poly_end <= nxt.pend;
        vtx_ch.mesh_end <= nxt.mend;
        vtx_gap = pick_pause();
      end
    end
  end

  always @(negedge clk) begin : box_taker
    if (rst_n) begin
      if (ready_stall > 0) begin
        box_ch.ready <= 1'b0;
        ready_stall--;
      end else begin
        box_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 4) == 0) ready_stall = pick_pause();
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, coord_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_M_XX:       xf_cfg.m_xx       = val;
      CFG_M_XY:       xf_cfg.m_xy       = val;
      CFG_M_YX:       xf_cfg.m_yx       = val;
      CFG_M_YY:       xf_cfg.m_yy       = val;
      CFG_SHIFT_X:    xf_cfg.shift_x    = val;
      CFG_SHIFT_Y:    xf_cfg.shift_y    = val;
      CFG_FAT_RADIUS: xf_cfg.fat_radius = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(coord_t a, coord_t b, coord_t c, coord_t d,
                              coord_t sx, coord_t sy, coord_t r, bit spare);
    write_reg(CFG_M_XX, a);
    write_reg(CFG_M_XY, b);
    write_reg(CFG_M_YX, c);
    write_reg(CFG_M_YY, d);
    write_reg(CFG_SHIFT_X, sx);
    write_reg(CFG_SHIFT_Y, sy);
    write_reg(CFG_FAT_RADIUS, r);
    if (spare) write_reg(CFG_IDX_SPARE, coord_t'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic coord_t pick_small(longint span);
    return coord_t'(longint'($urandom_range(0, 32'(2 * span))) - span);
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 4))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      3:       return COORD_ONE;
      default: return -COORD_ONE;
    endcase
  endfunction

  function automatic coord_t pick_radius();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      4, 5, 6:    return coord_t'($urandom_range(0, 262144));
      7:          return coord_t'(longint'(0) - longint'($urandom_range(1, 262144)));
      8:          return coord_t'($urandom);
      default:    return pick_extreme();
    endcase
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return pick_small(4194304);
      6, 7:             return coord_t'($urandom);
      8:                return coord_t'(COORD_MAX - coord_t'($urandom_range(0, 3)));
      default:          return coord_t'(COORD_MIN + coord_t'($urandom_range(0, 3)));
    endcase
  endfunction

  function automatic coord_t nudge(coord_t c);
    return coord_t'(clamp32(longint'(c) + longint'($urandom_range(0, 131072)) - 65536));
  endfunction

  task automatic program_random(int mode);
    case (mode)
      0: program_regs(COORD_ONE, '0, '0, COORD_ONE, pick_small(1 << 24), pick_small(1 << 24),
                      pick_radius(), 1'b0);
      1: program_regs(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                      pick_radius(), 1'b0);
      2: program_regs(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      pick_extreme(), pick_extreme(), pick_extreme(), 1'b1);
      3: program_regs(pick_small(1 << 17), pick_small(1 << 17), pick_small(1 << 17),
                      pick_small(1 << 17), pick_small(1 << 22), pick_small(1 << 22),
                      pick_radius(), 1'b0);
      // Negative radius: every polygon stays empty.
      4: program_regs(pick_small(1 << 17), pick_small(1 << 17), pick_small(1 << 17),
                      pick_small(1 << 17), pick_small(1 << 22), pick_small(1 << 22),
                      coord_t'(longint'(0) - longint'($urandom_range(1, 1048576))), 1'b0);
      default: program_regs(coord_t'($urandom), pick_small(1 << 17), pick_small(1 << 17),
                            coord_t'($urandom), pick_extreme(), coord_t'($urandom),
                            pick_radius(), 1'b1);
    endcase
  endtask

  function automatic void add_vertex(coord_t x, coord_t y, logic pe, logic me);
    vertex_t v;
    v.vx   = x;
    v.vy   = y;
    v.pend = pe;
    v.mend = me;
    vtx_pending.push_back(v);
  endfunction

  // Mostly well-formed meshes of clustered polygons, some point clouds, some noise.
  task automatic push_meshes(int unsigned want);
    int unsigned added;
    int unsigned shape;
    int unsigned n_poly;
    int unsigned n_vert;
    coord_t      base_x;
    coord_t      base_y;
    logic        last;
    added = 0;
    while (added < want) begin
      shape = $urandom_range(0, 9);
      if (shape == 9) begin
        n_vert = $urandom_range(1, 8);
        for (int unsigned k = 0; k < n_vert; k++) begin
          add_vertex(pick_coord(), pick_coord(), 1'($urandom_range(0, 1)), k == n_vert - 1);
          added++;
        end
      end else begin
        if (shape < 2) n_poly = $urandom_range(1, 12);
        else if ($urandom_range(0, 7) == 0) n_poly = $urandom_range(5, 15);
        else n_poly = $urandom_range(1, 4);
        for (int unsigned p = 0; p < n_poly; p++) begin
          n_vert = (shape < 2) ? 1 : $urandom_range(1, 6);
          base_x = pick_coord();
          base_y = pick_coord();
          for (int unsigned k = 0; k < n_vert; k++) begin
            last = (p == n_poly - 1) && (k == n_vert - 1);
            // The mesh-closing vertex may leave poly_end low.
            add_vertex(nudge(base_x), nudge(base_y),
                       (k == n_vert - 1) ? (last ? 1'($urandom_range(0, 1)) : 1'b1) : 1'b0,
                       last);
            added++;
          end
        end
      end
    end
  endtask

  // Hold until every queued vertex is in and every box is out, then let the pipe drain.
  task automatic settle();
    while (vtx_pending.size() != 0 || vtx_ch.valid || boxes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    xf_cfg.m_xx       = COORD_ONE;
    xf_cfg.m_xy       = '0;
    xf_cfg.m_yx       = '0;
    xf_cfg.m_yy       = COORD_ONE;
    xf_cfg.shift_x    = '0;
    xf_cfg.shift_y    = '0;
    xf_cfg.fat_radius = '0;
    poly_acc          = BOX_EMPTY;
    mesh_acc          = BOX_EMPTY;
    n_settings        = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: single-vertex mesh, open polygon closed by mesh end, extremes.
    add_vertex('0, '0, 1'b1, 1'b1);
    add_vertex(COORD_MAX, COORD_MIN, 1'b0, 1'b0);
    add_vertex(COORD_MIN, COORD_MAX, 1'b0, 1'b1);
    add_vertex(COORD_ONE, coord_t'(2 * COORD_ONE), 1'b0, 1'b0);
    add_vertex(-COORD_ONE, COORD_ONE, 1'b0, 1'b0);
    add_vertex(coord_t'(3 * COORD_ONE), -COORD_ONE, 1'b1, 1'b0);
    add_vertex(coord_t'(7), coord_t'(9), 1'b1, 1'b0);
    add_vertex(coord_t'(-5), coord_t'(-6), 1'b1, 1'b1);
    add_vertex(coord_t'(-1), coord_t'(-1), 1'b1, 1'b1);
    add_vertex(COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    add_vertex(COORD_MAX, COORD_MAX, 1'b0, 1'b1);
    settle();

    // Saturate everywhere: extreme matrix, shift and radius.
    program_regs(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                 COORD_MAX, 1'b1);
    add_vertex(COORD_MAX, COORD_MAX, 1'b1, 1'b0);
    add_vertex(COORD_MIN, COORD_MIN, 1'b0, 1'b1);
    add_vertex('0, '0, 1'b1, 1'b1);
    add_vertex(COORD_ONE, -COORD_ONE, 1'b1, 1'b1);
    settle();

    // Negative radius: polygons and meshes come out empty.
    program_regs(COORD_ONE, '0, '0, COORD_ONE, '0, '0, -COORD_ONE, 1'b0);
    add_vertex(coord_t'(5), coord_t'(5), 1'b1, 1'b1);
    add_vertex(COORD_MIN, COORD_MAX, 1'b0, 1'b1);
    add_vertex('0, '0, 1'b1, 1'b0);
    add_vertex(coord_t'(1), coord_t'(1), 1'b1, 1'b1);
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady = (ph % 4 == 3);
      program_random(ph % 6);
      push_meshes(PHASE_VERTICES);
      settle();
    end

    $display("tb: %0d vertices in %0d meshes (%0d empty) across %0d register settings",
             n_vertices, n_meshes, n_empty, n_settings);
    $display("tb: %0d mismatches", errors);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/tmbb_pkg.sv
rtl/tmbb_vtx_if.sv
rtl/tmbb_box_if.sv
rtl/tmbb_front.sv
rtl/tmbb_queue.sv
rtl/tmbb_back.sv
rtl/transformed_mesh_bounding_box_top.sv
bench/tb.sv
